/* rtl/core/u2u8_pkg.sv */
// Package of shared types and constants for the UTF-32 to UTF-8 packer.
`default_nettype none
package u2u8_pkg;

	// Number of code point lanes in one request.
	localparam int Lanes = 4;
	// Largest packed result in bytes.
	localparam int MaxBytes = 16;

	localparam int CpW = 21;
	localparam int LenW = 3;
	localparam int OffW = 4;
	localparam int CountW = 5;
	localparam int UsedW = 3;

	// High bits of a code point in the surrogate range, 0xD800 >> 11.
	localparam logic [CpW-12:0] SurrHigh = 10'h01B;

	// Lead and continuation byte marks.
	localparam logic [2:0] Lead2 = 3'b110;
	localparam logic [3:0] Lead3 = 4'b1110;
	localparam logic [4:0] Lead4 = 5'b11110;
	localparam logic [1:0] Cont = 2'b10;

	// One encoded lane: its byte count, its bytes with the first one lowest,
	// and whether it held a surrogate.
	typedef struct packed {
		logic [LenW-1:0] len;
		logic [31:0]     bytes;
		logic            surr;
	} lane_enc_t;

endpackage
`default_nettype wire

/* rtl/core/u2u8_lane_enc.sv */
// Encoder of one code point into one to four UTF-8 bytes.
`default_nettype none
module u2u8_lane_enc (
	input  wire logic [u2u8_pkg::CpW-1:0] cp,
	output u2u8_pkg::lane_enc_t           enc
);

	always_comb begin
		enc.surr = (cp[u2u8_pkg::CpW-1:11] == u2u8_pkg::SurrHigh);
		if (cp[u2u8_pkg::CpW-1:7] == '0) begin
			enc.len   = 3'd1;
			enc.bytes = {24'h0, 1'b0, cp[6:0]};
		end else if (cp[u2u8_pkg::CpW-1:11] == '0) begin
			enc.len   = 3'd2;
			enc.bytes = {16'h0, u2u8_pkg::Cont, cp[5:0], u2u8_pkg::Lead2, cp[10:6]};
		end else if (cp[u2u8_pkg::CpW-1:16] == '0) begin
			enc.len   = 3'd3;
			enc.bytes = {8'h0, u2u8_pkg::Cont, cp[5:0], u2u8_pkg::Cont, cp[11:6],
				u2u8_pkg::Lead3, cp[15:12]};
		end else begin
			enc.len   = 3'd4;
			enc.bytes = {u2u8_pkg::Cont, cp[5:0], u2u8_pkg::Cont, cp[11:6],
				u2u8_pkg::Cont, cp[17:12], u2u8_pkg::Lead4, cp[20:18]};
		end
	end

endmodule
`default_nettype wire

/* rtl/core/utf32_to_utf8_packer.sv */
// Top level of the UTF-32 to UTF-8 packer: a three-stage encode and pack pipeline.
`default_nettype none
// How the block is used.
// A request carries four code point lanes and a count of used lanes. It is
// taken at a rising clock edge at which start is high and busy is low; busy
// is always low, so a new request may be given in every cycle.
// Each request yields exactly one result, shown on bytes_low, bytes_high,
// byte_count and error for one clock cycle while done is high. The bytes of
// the used lanes are packed in lane order, the first byte in bits 7 to 0 of
// bytes_low; positions at or above byte_count read as zero. A surrogate in a
// used lane gives error high with no bytes and a zero count.
// The three register stages are lane encoding, byte offset prefix sum, and
// the shift and merge of the lanes; each takes a new request in every cycle
// and nothing stalls, so throughput is one request per cycle.
// Reset clears the valid bits of all stages, so no result appears after it.
// The receiver cannot stall; results are never held back or repeated.
module utf32_to_utf8_packer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [u2u8_pkg::CpW-1:0]      code_point_0,
	input  wire logic [u2u8_pkg::CpW-1:0]      code_point_1,
	input  wire logic [u2u8_pkg::CpW-1:0]      code_point_2,
	input  wire logic [u2u8_pkg::CpW-1:0]      code_point_3,
	input  wire logic [u2u8_pkg::UsedW-1:0]    lanes_used,
	output logic                               done,
	output logic [63:0]                        bytes_low,
	output logic [63:0]                        bytes_high,
	output logic [u2u8_pkg::CountW-1:0]        byte_count,
	output logic                               error
);

	localparam int L = u2u8_pkg::Lanes;

	// The pipeline never stalls, so a request is always taken.
	assign busy = 1'b0;

	logic [u2u8_pkg::CpW-1:0] cp_in [L];
	assign cp_in[0] = code_point_0;
	assign cp_in[1] = code_point_1;
	assign cp_in[2] = code_point_2;
	assign cp_in[3] = code_point_3;

	// Stage one: encode every lane and blank the lanes beyond the used count.
	// A count above the lane number is saturated to it.
	logic [u2u8_pkg::UsedW-1:0] used_sat;
	assign used_sat = (lanes_used > u2u8_pkg::UsedW'(L)) ? u2u8_pkg::UsedW'(L) : lanes_used;

	u2u8_pkg::lane_enc_t enc_c [L];
	u2u8_pkg::lane_enc_t enc_s1 [L];
	logic valid_s1;

	for (genvar g = 0; g < L; g++) begin : g_lane
		u2u8_lane_enc u_enc (
			.cp  (cp_in[g]),
			.enc (enc_c[g])
		);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < L; i++) begin
			if (u2u8_pkg::UsedW'(i) < used_sat) begin
				enc_s1[i] <= enc_c[i];
			end else begin
				enc_s1[i] <= '0;
			end
		end
	end

	// Stage two: the byte offset of each lane is the sum of the lengths before
	// it; the surrogate flags are gathered into one error bit.
	logic [u2u8_pkg::CountW-1:0] off_c [L+1];
	logic                        err_c;
	logic [u2u8_pkg::OffW-1:0]   off_s2 [L];
	logic [31:0]                 bytes_s2 [L];
	logic [u2u8_pkg::CountW-1:0] count_s2;
	logic                        err_s2;
	logic                        valid_s2;

	always_comb begin
		off_c[0] = '0;
		err_c    = 1'b0;
		for (int i = 0; i < L; i++) begin
			off_c[i+1] = off_c[i] + u2u8_pkg::CountW'(enc_s1[i].len);
			err_c      = err_c | enc_s1[i].surr;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < L; i++) begin
			off_s2[i]   <= off_c[i][u2u8_pkg::OffW-1:0];
			bytes_s2[i] <= enc_s1[i].bytes;
		end
		count_s2 <= off_c[L];
		err_s2   <= err_c;
	end

	// Stage three: shift each lane to its byte offset and merge. An error
	// result carries no bytes and a zero count.
	logic [8*u2u8_pkg::MaxBytes-1:0] merged_c;
	logic [8*u2u8_pkg::MaxBytes-1:0] merged_s3;
	logic [u2u8_pkg::CountW-1:0]     count_s3;
	logic                            err_s3;
	logic                            valid_s3;

	always_comb begin
		merged_c = '0;
		for (int i = 0; i < L; i++) begin
			merged_c = merged_c |
				((8*u2u8_pkg::MaxBytes)'(bytes_s2[i]) << {off_s2[i], 3'b000});
		end
	end

	always_ff @(posedge clk) begin
		merged_s3 <= err_s2 ? '0 : merged_c;
		count_s3  <= err_s2 ? '0 : count_s2;
		err_s3    <= err_s2;
	end

	// Valid bits travel with the data through the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign done       = valid_s3;
	assign bytes_low  = merged_s3[63:0];
	assign bytes_high = merged_s3[127:64];
	assign byte_count = count_s3;
	assign error      = err_s3;

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench of the UTF-32 to UTF-8 packer, with directed and random requests.
module tb;

	// The block takes a request on every cycle and answers after its pipeline.
	// The longest quiet spell of a correct run is the longest driver gap plus
	// the pipeline delay, so the watchdog limit below leaves a wide margin.
	localparam int IdleLimit      = 1000;
	localparam int DrainCycles    = 8;
	localparam int RandomRequests = 1930;

	// One request as the driver holds it: four code point lanes and a lane count.
	typedef struct packed {
		logic [u2u8_pkg::Lanes-1:0][u2u8_pkg::CpW-1:0] cp;
		logic [u2u8_pkg::UsedW-1:0]                    used;
	} cp_req_t;

	// One packed UTF-8 result, in the shape of the result ports.
	typedef struct packed {
		logic [63:0]                 lo;
		logic [63:0]                 hi;
		logic [u2u8_pkg::CountW-1:0] count;
		logic                        err;
	} utf8_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cp_req_t drv = '0;

	logic                        busy;
	logic                        done;
	logic [63:0]                 bytes_low;
	logic [63:0]                 bytes_high;
	logic [u2u8_pkg::CountW-1:0] byte_count;
	logic                        error;

	// Requests still to be driven, and results that accepted requests owe.
	cp_req_t    pending_reqs[$];
	utf8_word_t owed_words[$];

	// Set at each rising edge when the block took the request on its inputs.
	logic took = 1'b0;
	int   idle_cycles = 0;
	int   fails = 0;

	utf32_to_utf8_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.code_point_0 (drv.cp[0]),
		.code_point_1 (drv.cp[1]),
		.code_point_2 (drv.cp[2]),
		.code_point_3 (drv.cp[3]),
		.lanes_used   (drv.used),
		.done         (done),
		.bytes_low    (bytes_low),
		.bytes_high   (bytes_high),
		.byte_count   (byte_count),
		.error        (error)
	);

	always #4 clk = ~clk;

	// Reset is held low from the start and released on a falling edge, well away
	// from the rising edge at which the block samples its inputs.
	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
	end

	// Works out the UTF-8 result that a request must give. A lane count above
	// the number of lanes is saturated, and only the used lanes are looked at,
	// both for the surrogate check and for encoding. A surrogate anywhere in
	// the used lanes gives an error with no bytes and a zero count. Code points
	// above the Unicode range are still encoded as four bytes, their top three
	// bits landing in the lead byte.
	function automatic utf8_word_t encode_request(cp_req_t r);
		utf8_word_t               w;
		logic [127:0]             packed_bytes;
		logic [31:0]              seq;
		logic [u2u8_pkg::CpW-1:0] c;
		int                       lanes, len, n, i, k;
		logic                     surr;
		w = '0;
		packed_bytes = '0;
		n = 0;
		surr = 1'b0;
		seq = '0;
		len = 0;
		lanes = (int'(r.used) > u2u8_pkg::Lanes) ? u2u8_pkg::Lanes : int'(r.used);
		for (i = 0; i < lanes; i++)
			if (r.cp[i][u2u8_pkg::CpW-1:11] == 10'h01B)
				surr = 1'b1;
		if (surr) begin
			w.err = 1'b1;
			return w;
		end
		for (i = 0; i < lanes; i++) begin
			c = r.cp[i];
			// The sequence is built with its first byte lowest.
			if (c < 21'h80) begin
				len = 1;
				seq = {24'h0, c[7:0]};
			end else if (c < 21'h800) begin
				len = 2;
				seq = {16'h0, 2'b10, c[5:0], 3'b110, c[10:6]};
			end else if (c < 21'h10000) begin
				len = 3;
				seq = {8'h0, 2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
			end else begin
				len = 4;
				seq = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12], 5'b11110, c[20:18]};
			end
			for (k = 0; k < len; k++)
				if (n < u2u8_pkg::MaxBytes) begin
					packed_bytes[8*n +: 8] = seq[8*k +: 8];
					n++;
				end
		end
		w.lo = packed_bytes[63:0];
		w.hi = packed_bytes[127:64];
		w.count = n[u2u8_pkg::CountW-1:0];
		return w;
	endfunction

	task automatic queue_request(input logic [u2u8_pkg::CpW-1:0] c0,
			input logic [u2u8_pkg::CpW-1:0] c1, input logic [u2u8_pkg::CpW-1:0] c2,
			input logic [u2u8_pkg::CpW-1:0] c3, input logic [u2u8_pkg::UsedW-1:0] u);
		cp_req_t r;
		r.cp[0] = c0;
		r.cp[1] = c1;
		r.cp[2] = c2;
		r.cp[3] = c3;
		r.used = u;
		pending_reqs.push_back(r);
	endtask

	// Driver. Inputs change only on the falling edge. A request stays on the
	// inputs until the block has taken it; after that the driver either puts
	// the next request up at once, keeping start high without a glitch, or
	// idles for a drawn number of cycles. Now and then it runs a stretch of
	// back-to-back requests, so that the pipeline is also kept full.
	always @(negedge clk) begin : driver
		int gap_left;
		int steady_left;
		if (arst_n && !(start && !took)) begin
			if (start) begin
				if (steady_left > 0) begin
					steady_left--;
					gap_left = 0;
				end else if ($urandom_range(0, 7) == 0) begin
					steady_left = $urandom_range(10, 40);
					gap_left = 0;
				end else begin
					gap_left = $urandom_range(0, 9);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				drv <= pending_reqs.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor. On each rising edge it first checks any result on the ports
	// against the oldest owed result, then notes whether the request on the
	// inputs was taken and, if so, records what that request must give. The
	// result of a request taken at this edge must first pass through the
	// registered pipeline, so checking before recording is safe.
	always @(posedge clk) begin : monitor
		utf8_word_t want;
		took = arst_n && start && !busy;
		if (done) begin
			if (owed_words.size() == 0) begin
				$error("result with no request outstanding: bytes_low %h byte_count %0d",
					bytes_low, byte_count);
				fails++;
			end else begin
				want = owed_words.pop_front();
				if (bytes_low !== want.lo) begin
					$error("bytes_low: expected %h, got %h", want.lo, bytes_low);
					fails++;
				end
				if (bytes_high !== want.hi) begin
					$error("bytes_high: expected %h, got %h", want.hi, bytes_high);
					fails++;
				end
				if (byte_count !== want.count) begin
					$error("byte_count: expected %0d, got %0d", want.count, byte_count);
					fails++;
				end
				if (error !== want.err) begin
					$error("error: expected %b, got %b", want.err, error);
					fails++;
				end
			end
		end
		if (took)
			owed_words.push_back(encode_request(drv));
		idle_cycles = (took || done) ? 0 : idle_cycles + 1;
	end

	// Stimulus and end of run.
	initial begin : stimulus
		cp_req_t r;
		int      sel, i, lane;
		logic    timed_out;

		// Directed part: the size boundaries of each encoding, full sixteen
		// byte results, surrogates at both ends of their range and in the
		// first and last used lane, surrogates in unused lanes, zero lanes,
		// lane counts above four, and code points beyond the Unicode range.
		queue_request(21'h0, 21'h0, 21'h0, 21'h0, 3'd1);
		queue_request(21'h7F, 21'h80, 21'h7FF, 21'h800, 3'd4);
		queue_request(21'hFFFF, 21'h10000, 21'h10FFFF, 21'h110000, 3'd4);
		queue_request(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 3'd4);
		queue_request(21'h10000, 21'h10000, 21'h10000, 21'h10000, 3'd4);
		queue_request(21'hD7FF, 21'hE000, 21'h0, 21'h0, 3'd2);
		queue_request(21'hD800, 21'h41, 21'h42, 21'h43, 3'd1);
		queue_request(21'h41, 21'h42, 21'h43, 21'hDFFF, 3'd4);
		queue_request(21'hDC00, 21'h41, 21'h0, 21'h0, 3'd2);
		queue_request(21'h20AC, 21'h3B1, 21'hD800, 21'hDFFF, 3'd2);
		queue_request(21'hD800, 21'hDBFF, 21'hDC00, 21'hDFFF, 3'd0);
		queue_request(21'h1F600, 21'h41, 21'hE9, 21'h4E2D, 3'd5);
		queue_request(21'h24, 21'hA2, 21'h939, 21'h10348, 3'd6);
		queue_request(21'h41, 21'h42, 21'h43, 21'hDABC, 3'd7);
		queue_request(21'h1FD800, 21'h15A5A5, 21'h0AAAA, 21'h155555, 3'd4);
		queue_request(21'h140000, 21'h7F, 21'h7C0, 21'hFFFE, 3'd3);
		queue_request(21'h1FFFFF, 21'h0, 21'h0, 21'h0, 3'd1);
		queue_request(21'h555, 21'h2AA, 21'h1AAAAA, 21'h0, 3'd3);

		// Random part. Most requests are well formed with a mix of sequence
		// lengths; a few carry surrogates, zero lanes or an oversized lane
		// count, and some use only four-byte code points to fill all sixteen
		// bytes. Unused lanes carry the same random mix, surrogates included.
		for (i = 0; i < RandomRequests; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 4)
				r.used = 3'd0;
			else if (sel < 9)
				r.used = u2u8_pkg::UsedW'($urandom_range(5, 7));
			else
				r.used = u2u8_pkg::UsedW'($urandom_range(1, 4));
			for (lane = 0; lane < u2u8_pkg::Lanes; lane++) begin
				sel = (i % 10 == 0) ? 80 : $urandom_range(0, 99);
				if (sel < 30)
					r.cp[lane] = u2u8_pkg::CpW'($urandom_range(0, 'h7F));
				else if (sel < 50)
					r.cp[lane] = u2u8_pkg::CpW'($urandom_range('h80, 'h7FF));
				else if (sel < 60)
					r.cp[lane] = u2u8_pkg::CpW'($urandom_range('h800, 'hD7FF));
				else if (sel < 70)
					r.cp[lane] = u2u8_pkg::CpW'($urandom_range('hE000, 'hFFFF));
				else if (sel < 72)
					r.cp[lane] = u2u8_pkg::CpW'($urandom_range('hD800, 'hDFFF));
				else if (sel < 92)
					r.cp[lane] = u2u8_pkg::CpW'($urandom_range('h10000, 'h10FFFF));
				else
					r.cp[lane] = u2u8_pkg::CpW'($urandom_range('h110000, 'h1FFFFF));
			end
			pending_reqs.push_back(r);
		end

		// Wait for every request to be taken and every result to come back,
		// or for the watchdog to see too long a spell with nothing accepted or returned.
		timed_out = 1'b0;
		while (!(pending_reqs.size() == 0 && !start && owed_words.size() == 0)
				&& !timed_out) begin
			@(posedge clk);
			timed_out = (idle_cycles >= IdleLimit);
		end
		// A drain period of DrainCycles clocks catches any stray result after the last one.
		if (!timed_out)
			repeat (DrainCycles) @(posedge clk);
		if (fails == 0 && !timed_out)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/core/u2u8_pkg.sv
rtl/core/u2u8_lane_enc.sv
rtl/core/utf32_to_utf8_packer.sv
tb/sv/tb.sv
